>>> rtl/sigmoid_neuron_delta_rule_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef SIGMOID_NEURON_DELTA_RULE_UNIT_MACROS_SVH
`define SIGMOID_NEURON_DELTA_RULE_UNIT_MACROS_SVH

// Clocked assertion with synchronous active-low reset disable.
`define SND_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset names.
`define SND_ASSERT(lbl, prop, msg) \
    `SND_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

>>> rtl/snd_pkg.sv
package snd_pkg;

    localparam int NUM_INPUTS  = 8;
    localparam int SIG_DEPTH   = 256;
    localparam int SIG_AW      = $clog2(SIG_DEPTH);
    localparam int RE_W        = 33;
    localparam int PROD_W      = RE_W + 16;
    localparam int SUM_W       = 32 + $clog2(NUM_INPUTS) + 1;
    localparam int CFG_IDX_W   = 3;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_TRAIN = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IRATE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USED   = 3'd3;

    localparam logic [15:0] RATE_RESET  = 16'd3277;
    localparam logic [15:0] DECAY_RESET = 16'd66;
    localparam logic [3:0]  USED_RESET  = 4'd8;
    localparam logic [12:0] ACT_RESET   = 13'd2048;

    typedef struct packed {
        logic push;      // latch input, form w*x
        logic load_w;    // weight load
        logic mul_train; // form rate*err*held
        logic upd;       // apply delta
        logic active;
    } t_lane_ctl;

    typedef struct packed {
        logic sum_en;
    } t_merge_ctl;

    typedef logic [12:0] t_sig_table [SIG_DEPTH];

    // Unsigned shift-subtract quotient, used only while building the table.
    function automatic longint unsigned f_udiv(longint unsigned num, longint unsigned den);
        longint unsigned q, r;
        begin
            q = '0;
            r = '0;
            for (int b = 63; b >= 0; b--) begin
                r = {r[62:0], num[b]};
                if (r >= den) begin
                    r    = r - den;
                    q[b] = 1'b1;
                end
            end
            f_udiv = q;
        end
    endfunction

    // Sigmoid of x (Q4.12) in Q12, series plus repeated squaring.
    function automatic logic [12:0] f_sig_entry(longint x);
        longint unsigned y, u, u2, u3, p, d, q30, r;
        begin
            q30 = 64'd1 << 30;
            y   = (x < 0) ? longint'(-x) : longint'(x);
            u   = y << 10;
            u2  = (u * u) >> 30;
            u3  = (u2 * u) >> 30;
            p   = q30 - u + (u2 >> 1) - f_udiv(u3, 64'd6);
            for (int k = 0; k < 8; k++) begin
                p = (p * p) >> 30;
            end
            d = q30 + p;
            if (x >= 0) begin
                r = f_udiv((64'd1 << 42) + (d >> 1), d);
            end else begin
                r = f_udiv((p << 12) + (d >> 1), d);
            end
            f_sig_entry = r[12:0];
        end
    endfunction

    function automatic t_sig_table f_sig_table();
        t_sig_table t;
        longint xk;
        begin
            for (int k = 0; k < SIG_DEPTH; k++) begin
                xk = (longint'(k) * 65536) / SIG_DEPTH - 32768;
                t[k] = f_sig_entry(xk);
            end
            f_sig_table = t;
        end
    endfunction

    localparam t_sig_table SIG_TABLE = f_sig_table();

endpackage

>>> rtl/snd_if.sv
interface snd_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic signed [15:0] in_0;
    logic signed [15:0] in_1;
    logic signed [15:0] in_2;
    logic signed [15:0] in_3;
    logic signed [15:0] in_4;
    logic signed [15:0] in_5;
    logic signed [15:0] in_6;
    logic signed [15:0] in_7;
    logic signed [15:0] target;
    modport source (output valid, op, in_0, in_1, in_2, in_3, in_4, in_5, in_6, in_7,
                    target, input ready);
    modport sink   (input valid, op, in_0, in_1, in_2, in_3, in_4, in_5, in_6, in_7,
                    target, output ready);
endinterface

interface snd_out_if;
    logic               valid;
    logic               ready;
    logic [12:0]        activation;
    logic signed [15:0] error_value;
    logic               saturated;
    modport source (output valid, activation, error_value, saturated, input ready);
    modport sink   (input valid, activation, error_value, saturated, output ready);
endinterface

interface snd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/snd_lane.sv
module snd_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  snd_pkg::t_lane_ctl                i_ctl,
    input  logic signed [15:0]                i_x,
    input  logic signed [snd_pkg::RE_W-1:0]   i_re,
    output logic signed [31:0]                o_prod,
    output logic                              o_sat
);
    import snd_pkg::*;

    logic signed [15:0]       r_w, n_w;
    logic signed [15:0]       r_held, n_held;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [PROD_W-29:0] dlt;
    logic signed [PROD_W-28:0] wsum;
    logic signed [31:0]       wx;

    assign wx   = r_w * i_x;             // full 32-bit product
    assign dlt  = r_prod[PROD_W-1:28];   // floor shift
    assign wsum = (PROD_W-27)'(r_w) + (PROD_W-27)'(dlt);

    always_comb begin
        n_w    = r_w;
        n_held = r_held;
        n_prod = r_prod;
        o_sat  = 1'b0;
        if (i_ctl.load_w) begin
            n_w = i_x;
        end
        if (i_ctl.push) begin
            n_held = i_ctl.active ? i_x : 16'sd0;
            n_prod = i_ctl.active ? PROD_W'(wx) : '0;
        end
        if (i_ctl.mul_train) begin
            n_prod = PROD_W'(i_re) * PROD_W'(r_held);
        end
        if (i_ctl.upd && i_ctl.active) begin
            if (wsum > (PROD_W-27)'(32767)) begin
                n_w   = 16'sh7FFF;
                o_sat = 1'b1;
            end else if (wsum < -(PROD_W-27)'(32768)) begin
                n_w   = -16'sh8000;
                o_sat = 1'b1;
            end else begin
                n_w = wsum[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= '0;
            r_held <= '0;
        end else begin
            r_w    <= n_w;
            r_held <= n_held;
        end
        r_prod <= n_prod;
    end

    assign o_prod = r_prod[31:0];

endmodule

>>> rtl/snd_merge.sv
module snd_merge (
    input  logic                 i_clk,
    input  snd_pkg::t_merge_ctl  i_ctl,
    input  logic signed [31:0]   i_prods [snd_pkg::NUM_INPUTS],
    output logic [12:0]          o_act,
    output logic                 o_sat
);
    import snd_pkg::*;

    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic signed [SUM_W-13:0]  shr;
    logic [15:0]               s16;
    logic [15:0]               ofs;

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < NUM_INPUTS; k++) begin
            n_sum = n_sum + SUM_W'(i_prods[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_en) begin
            r_sum <= n_sum;
        end
    end

    assign shr = r_sum[SUM_W-1:12];

    always_comb begin
        o_sat = 1'b0;
        if (shr > (SUM_W-12)'(32767)) begin
            s16   = 16'h7FFF;
            o_sat = 1'b1;
        end else if (shr < -(SUM_W-12)'(32768)) begin
            s16   = 16'h8000;
            o_sat = 1'b1;
        end else begin
            s16 = shr[15:0];
        end
        ofs   = {~s16[15], s16[14:0]};
        o_act = SIG_TABLE[ofs[15 -: SIG_AW]];
    end

endmodule

>>> rtl/sigmoid_neuron_delta_rule_unit.sv
// Channel   Dir  Payload                                   Transfer
// i_in      in   op, in_0..in_7, target                    valid & ready
// o_out     out  activation, error_value, saturated        valid & ready
// i_cfg     in   index, data (write only)                  valid & ready
//
// Push steps through P1 and P2, train through T1 to T5; load and the unused op give their result from idle.
// Train length is set by the chain g -> error -> rate*error -> lane multiply -> update.
// One item in flight; i_in is ready only when idle with the result register empty.
// i_rst_n is synchronous: weights, held inputs, error clear, activation goes to 2048.
// Result holds on o_out until taken; config is always ready.
module sigmoid_neuron_delta_rule_unit (
    input  logic  i_clk,
    input  logic  i_rst_n,
    snd_in_if.sink    i_in,
    snd_out_if.source o_out,
    snd_cfg_if.sink   i_cfg
);
    import snd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_P1   = 3'd1;  // lane products valid, sum them
    localparam logic [2:0] ST_P2   = 3'd2;  // clamp, table, result
    localparam logic [2:0] ST_T1   = 3'd3;  // g = a*(1-a)
    localparam logic [2:0] ST_T2   = 3'd4;  // error, decay amount
    localparam logic [2:0] ST_T3   = 3'd5;  // rate*error
    localparam logic [2:0] ST_T4   = 3'd6;  // lane multiply, rate decay
    localparam logic [2:0] ST_T5   = 3'd7;  // weight update, result

    logic [2:0]         r_state, n_state;
    logic               r_out_valid, n_out_valid;
    logic               r_hidden;
    logic [15:0]        r_init_rate;
    logic [15:0]        r_decay;
    logic [3:0]         r_used;
    logic [15:0]        r_rate, n_rate;
    logic [12:0]        r_act, n_act;
    logic signed [15:0] r_err, n_err;
    logic               r_sat, n_sat;
    logic signed [15:0] r_tgt;
    logic [10:0]        r_g;
    logic signed [17:0] r_diff;
    logic [15:0]        r_dec;
    logic signed [RE_W-1:0] r_re;

    logic               in_fire;
    logic               cfg_fire;
    logic signed [15:0] lane_x   [NUM_INPUTS];
    logic signed [31:0] lane_prod[NUM_INPUTS];
    logic [NUM_INPUTS-1:0] lane_sat;
    t_lane_ctl          lane_ctl [NUM_INPUTS];
    t_merge_ctl         merge_ctl;
    logic [12:0]        merge_act;
    logic               merge_sat;
    logic [25:0]        g_full;
    logic signed [29:0] e_full;
    logic signed [17:0] e_shr;
    logic [31:0]        dec_full;

    assign in_fire  = i_in.valid && i_in.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign i_in.ready  = (r_state == ST_IDLE) && !r_out_valid;
    assign i_cfg.ready = 1'b1;

    assign lane_x[0] = i_in.in_0;
    assign lane_x[1] = i_in.in_1;
    assign lane_x[2] = i_in.in_2;
    assign lane_x[3] = i_in.in_3;
    assign lane_x[4] = i_in.in_4;
    assign lane_x[5] = i_in.in_5;
    assign lane_x[6] = i_in.in_6;
    assign lane_x[7] = i_in.in_7;

    // Lane controls; a lane takes part when its number is below inputs_used.
    always_comb begin
        for (int k = 0; k < NUM_INPUTS; k++) begin
            lane_ctl[k].push      = in_fire && (i_in.op == OP_PUSH);
            lane_ctl[k].load_w    = in_fire && (i_in.op == OP_LOAD);
            lane_ctl[k].mul_train = (r_state == ST_T4);
            lane_ctl[k].upd       = (r_state == ST_T5);
            lane_ctl[k].active    = (4'(k) < r_used);
        end
        merge_ctl.sum_en = (r_state == ST_P1);
    end

    for (genvar k = 0; k < NUM_INPUTS; k++) begin : g_lane
        snd_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl[k]),
            .i_x     (lane_x[k]),
            .i_re    (r_re),
            .o_prod  (lane_prod[k]),
            .o_sat   (lane_sat[k])
        );
    end

    snd_merge u_merge (
        .i_clk   (i_clk),
        .i_ctl   (merge_ctl),
        .i_prods (lane_prod),
        .o_act   (merge_act),
        .o_sat   (merge_sat)
    );

    // Training datapath: g, error, decay amount and rate*error.
    assign g_full   = r_act * (13'd4096 - r_act);
    assign e_full   = $signed({1'b0, r_g}) * r_diff;
    assign e_shr    = e_full[29:12];
    assign dec_full = r_rate * r_decay;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_tgt <= i_in.target;
        end
        r_g    <= g_full[22:12];
        r_diff <= r_hidden ? 18'(r_tgt) : 18'(r_tgt) - 18'($signed({1'b0, r_act}));
        r_dec  <= dec_full[31:16];
        r_re   <= $signed({1'b0, r_rate}) * RE_W'(r_err);
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_rate      = r_rate;
        n_act       = r_act;
        n_err       = r_err;
        n_sat       = r_sat;
        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_sat = 1'b0;
                    case (i_in.op)
                        OP_PUSH:  n_state = ST_P1;
                        OP_TRAIN: n_state = ST_T1;
                        OP_LOAD: begin
                            n_rate      = r_init_rate;
                            n_out_valid = 1'b1;
                        end
                        default:  n_out_valid = 1'b1;
                    endcase
                end
            end
            ST_P1: n_state = ST_P2;
            ST_P2: begin
                n_act       = merge_act;
                n_sat       = merge_sat;
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_T1: n_state = ST_T2;
            ST_T2: begin
                if (e_shr > 18'sd32767) begin
                    n_err = 16'sh7FFF;
                    n_sat = 1'b1;
                end else if (e_shr < -18'sd32768) begin
                    n_err = -16'sh8000;
                    n_sat = 1'b1;
                end else begin
                    n_err = e_shr[15:0];
                end
                n_state = ST_T3;
            end
            ST_T3: n_state = ST_T4;
            ST_T4: begin
                n_rate  = r_rate - r_dec;   // r_re already took the old rate
                n_state = ST_T5;
            end
            ST_T5: begin
                n_sat       = r_sat || (|lane_sat);
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_hidden    <= 1'b0;
            r_init_rate <= RATE_RESET;
            r_decay     <= DECAY_RESET;
            r_used      <= USED_RESET;
            r_rate      <= RATE_RESET;
            r_act       <= ACT_RESET;
            r_err       <= '0;
            r_sat       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rate      <= n_rate;
            r_act       <= n_act;
            r_err       <= n_err;
            r_sat       <= n_sat;
            if (cfg_fire) begin
                unique case (i_cfg.index)
                    CFG_HIDDEN: r_hidden    <= i_cfg.data[0];
                    CFG_IRATE:  r_init_rate <= i_cfg.data;
                    CFG_DECAY:  r_decay     <= i_cfg.data;
                    CFG_USED:   r_used      <= i_cfg.data[3:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.activation  = r_act;
    assign o_out.error_value = r_err;
    assign o_out.saturated   = r_sat;

endmodule

>>> rtl/snd_checker.sv
`include "sigmoid_neuron_delta_rule_unit_macros.svh"

module snd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_op,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [12:0] i_out_act
);
    import snd_pkg::*;

    `SND_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped")
    `SND_ASSERT(a_one_item, i_in_valid && i_in_ready |-> !i_out_valid, "accept while busy")
    `SND_ASSERT(a_act_range, i_out_valid |-> i_out_act <= 13'd4096, "activation out of range")
    `SND_ASSERT(a_load_fast, i_in_valid && i_in_ready && i_in_op[1] |=> i_out_valid, "load late")

endmodule

bind sigmoid_neuron_delta_rule_unit snd_checker u_snd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_act   (o_out.activation)
);
